@@ src/stpp_pkg.sv @@
// Package with the shared types and constants of the stepper preset positioner.
package stpp_pkg;

    // Widths fixed by the register and field formats.
    localparam int CFG_DATA_BITS = 16;
    localparam int NUDGE_BITS    = 10;
    localparam int ANGLE_BITS    = 8;
    localparam int PRESET_BITS   = 16;
    localparam int OUT_POS_BITS  = 16;
    localparam int BUTTON_COUNT  = 5;

    // Bit positions of the buttons in the packed button vector.
    localparam int BTN_TRIANGLE = 0;
    localparam int BTN_CROSS    = 1;
    localparam int BTN_SQUARE   = 2;
    localparam int BTN_UP       = 3;
    localparam int BTN_DOWN     = 4;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_TAKE_POSITION    = 3'd0,
        CFG_DROP_POSITION    = 3'd1,
        CFG_DOCK_POSITION    = 3'd2,
        CFG_NUDGE_SIZE       = 3'd3,
        CFG_TAKE_SERVO_THR   = 3'd4,
        CFG_RETURN_SERVO_THR = 3'd5,
        CFG_SERVO_TAKE_ANGLE = 3'd6,
        CFG_SERVO_DOCK_ANGLE = 3'd7
    } t_cfg_index;

    // Reset values of the configuration registers.
    localparam logic signed [PRESET_BITS-1:0] TAKE_POSITION_RST    = 16'sd2075;
    localparam logic signed [PRESET_BITS-1:0] DROP_POSITION_RST    = 16'sd2085;
    localparam logic signed [PRESET_BITS-1:0] DOCK_POSITION_RST    = -16'sd1500;
    localparam logic        [NUDGE_BITS-1:0]  NUDGE_SIZE_RST       = 10'd50;
    localparam logic signed [PRESET_BITS-1:0] TAKE_SERVO_THR_RST   = 16'sd1000;
    localparam logic signed [PRESET_BITS-1:0] RETURN_SERVO_THR_RST = 16'sd3000;
    localparam logic        [ANGLE_BITS-1:0]  SERVO_TAKE_ANGLE_RST = 8'd42;
    localparam logic        [ANGLE_BITS-1:0]  SERVO_DOCK_ANGLE_RST = 8'd128;

endpackage

@@ src/stepper_preset_positioner_top.sv @@
// Top level of the stepper preset positioner: button edges, target, motor and servo control.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | five button levels, ms tick
//  out     | output    | o_out_valid / i_out_stall | run, ccw, position, servo write, angle
//  cfg     | input     | i_cfg_valid / o_cfg_ready | register index, 16-bit write data
//
//  Every input transaction is one control pass. Its result is registered and shows in the
//  cycle after acceptance, so one pass per clock is sustained unless the output stalls;
//  the single output register sets that figure. The whole pass is one combinational path
//  from the state registers. A new transaction is taken whenever the output register is
//  empty or being emptied; only a stalled, full output register stalls the input.
//  Synchronous active-low reset clears control state and reloads the configuration
//  registers with their default presets. The configuration port is always ready.
module stepper_preset_positioner_top #(
    parameter int POSITION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_button_triangle,
    input  logic                          i_button_cross,
    input  logic                          i_button_square,
    input  logic                          i_button_up,
    input  logic                          i_button_down,
    input  logic                          i_ms_tick,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_motor_run,
    output logic                          o_motor_ccw,
    output logic signed [15:0]            o_position_now,
    output logic                          o_servo_write,
    output logic        [7:0]             o_servo_angle,
    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  stpp_pkg::t_cfg_index          i_cfg_index,
    input  logic [stpp_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import stpp_pkg::*;

    // Working width: wide enough for a 16-bit preset or threshold and for a position
    // plus or minus the nudge, with room so that the clamp sees the overflow.
    localparam int XW = ((POSITION_BITS > PRESET_BITS) ? POSITION_BITS : PRESET_BITS) + 2;

    // Signed range of a position register, extended to the working width.
    localparam logic signed [XW-1:0] POS_MAX =
        {{(XW-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [XW-1:0] POS_MIN =
        {{(XW-POSITION_BITS+1){1'b1}}, {(POSITION_BITS-1){1'b0}}};

    // Configuration registers.
    logic signed [PRESET_BITS-1:0] r_take_position;
    logic signed [PRESET_BITS-1:0] r_drop_position;
    logic signed [PRESET_BITS-1:0] r_dock_position;
    logic        [NUDGE_BITS-1:0]  r_nudge_size;
    logic signed [PRESET_BITS-1:0] r_take_servo_thr;
    logic signed [PRESET_BITS-1:0] r_return_servo_thr;
    logic        [ANGLE_BITS-1:0]  r_servo_take_angle;
    logic        [ANGLE_BITS-1:0]  r_servo_dock_angle;

    // Control state carried from pass to pass.
    logic [BUTTON_COUNT-1:0]          r_prev_buttons;
    logic                             r_take_toggle;
    logic                             r_return_pending;
    logic signed [POSITION_BITS-1:0]  r_target;
    logic signed [POSITION_BITS-1:0]  r_position;
    logic                             r_running;
    logic                             r_direction;

    // Output register. Run, direction and position come straight from the state
    // registers, which only change when a transaction is accepted.
    logic                             r_out_valid;
    logic                             r_servo_write;
    logic        [ANGLE_BITS-1:0]     r_servo_angle;

    // Next values of one control pass.
    logic [BUTTON_COUNT-1:0]          n_buttons;
    logic [BUTTON_COUNT-1:0]          n_rise;
    logic                             n_take_toggle;
    logic                             n_return_pending;
    logic signed [XW-1:0]             n_target_x;
    logic signed [XW-1:0]             n_position_x;
    logic                             n_running;
    logic                             n_direction;
    logic                             n_servo_write;
    logic        [ANGLE_BITS-1:0]     n_servo_angle;

    logic signed [XW-1:0]             w_position_x;
    logic signed [XW-1:0]             w_nudge_x;
    logic                             w_in_accept;

    function automatic logic signed [XW-1:0] sext_preset(
        input logic signed [PRESET_BITS-1:0] v
    );
        return {{(XW-PRESET_BITS){v[PRESET_BITS-1]}}, v};
    endfunction

    function automatic logic signed [XW-1:0] sext_pos(
        input logic signed [POSITION_BITS-1:0] v
    );
        return {{(XW-POSITION_BITS){v[POSITION_BITS-1]}}, v};
    endfunction

    // Saturate a working-width value to the position range.
    function automatic logic signed [XW-1:0] clamp_pos(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = v;
        if (v > POS_MAX) begin
            r = POS_MAX;
        end else if (v < POS_MIN) begin
            r = POS_MIN;
        end
        return r;
    endfunction

    // Handshakes. The output register can take a new result when it is empty or
    // when its current result leaves in this cycle.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_position_x = sext_pos(r_position);
    assign w_nudge_x    = $signed({{(XW-NUDGE_BITS){1'b0}}, r_nudge_size});

    assign n_buttons = {i_button_down, i_button_up, i_button_square,
                        i_button_cross, i_button_triangle};

    // One control pass: button edges update the target in a fixed order (a later setting edge
    // overrides, a nudge shifts the target so far), then the motor decision, then at most one step.
    always_comb begin
        n_rise           = n_buttons & ~r_prev_buttons;
        n_take_toggle    = r_take_toggle;
        n_return_pending = r_return_pending;
        n_target_x       = sext_pos(r_target);

        if (n_rise[BTN_TRIANGLE]) begin
            n_take_toggle = !r_take_toggle;
            if (n_take_toggle) begin
                n_target_x = clamp_pos(sext_preset(r_take_position));
            end else begin
                // Entering the dock side arms the servo return.
                n_target_x       = clamp_pos(sext_preset(r_dock_position));
                n_return_pending = 1'b1;
            end
        end
        if (n_rise[BTN_DOWN]) begin
            n_target_x = clamp_pos(n_target_x - w_nudge_x);
        end
        if (n_rise[BTN_UP]) begin
            n_target_x = clamp_pos(n_target_x + w_nudge_x);
        end
        if (n_rise[BTN_SQUARE]) begin
            n_target_x = '0;
        end
        if (n_rise[BTN_CROSS]) begin
            n_target_x = clamp_pos(sext_preset(r_drop_position));
        end

        // Motor decision. When the target is reached the direction keeps its value.
        n_direction = r_direction;
        n_running   = 1'b0;
        if (w_position_x < n_target_x) begin
            n_direction = 1'b1;
            n_running   = 1'b1;
        end else if (w_position_x > n_target_x) begin
            n_direction = 1'b0;
            n_running   = 1'b1;
        end

        // Step counting and servo commands on a millisecond tick. A return armed by
        // this same pass already counts for the downward step.
        n_position_x  = w_position_x;
        n_servo_write = 1'b0;
        n_servo_angle = '0;
        if (i_ms_tick && n_running) begin
            if (n_direction) begin
                n_position_x = w_position_x + XW'(1);
                if (n_position_x > sext_preset(r_take_servo_thr)) begin
                    n_servo_write = 1'b1;
                    n_servo_angle = r_servo_take_angle;
                end
            end else begin
                n_position_x = w_position_x - XW'(1);
                if (n_return_pending && (n_position_x < sext_preset(r_return_servo_thr))) begin
                    n_servo_write    = 1'b1;
                    n_servo_angle    = r_servo_dock_angle;
                    n_return_pending = 1'b0;
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_take_position    <= TAKE_POSITION_RST;
            r_drop_position    <= DROP_POSITION_RST;
            r_dock_position    <= DOCK_POSITION_RST;
            r_nudge_size       <= NUDGE_SIZE_RST;
            r_take_servo_thr   <= TAKE_SERVO_THR_RST;
            r_return_servo_thr <= RETURN_SERVO_THR_RST;
            r_servo_take_angle <= SERVO_TAKE_ANGLE_RST;
            r_servo_dock_angle <= SERVO_DOCK_ANGLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TAKE_POSITION:    r_take_position    <= $signed(i_cfg_data);
                CFG_DROP_POSITION:    r_drop_position    <= $signed(i_cfg_data);
                CFG_DOCK_POSITION:    r_dock_position    <= $signed(i_cfg_data);
                CFG_NUDGE_SIZE:       r_nudge_size       <= i_cfg_data[NUDGE_BITS-1:0];
                CFG_TAKE_SERVO_THR:   r_take_servo_thr   <= $signed(i_cfg_data);
                CFG_RETURN_SERVO_THR: r_return_servo_thr <= $signed(i_cfg_data);
                CFG_SERVO_TAKE_ANGLE: r_servo_take_angle <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_SERVO_DOCK_ANGLE: r_servo_dock_angle <= i_cfg_data[ANGLE_BITS-1:0];
            endcase
        end
    end

    // Control state, updated once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons   <= '0;
            r_take_toggle    <= 1'b0;
            r_return_pending <= 1'b0;
            r_target         <= '0;
            r_position       <= '0;
            r_running        <= 1'b0;
            r_direction      <= 1'b0;
        end else if (w_in_accept) begin
            r_prev_buttons   <= n_buttons;
            r_take_toggle    <= n_take_toggle;
            r_return_pending <= n_return_pending;
            r_target         <= n_target_x[POSITION_BITS-1:0];
            r_position       <= n_position_x[POSITION_BITS-1:0];
            r_running        <= n_running;
            r_direction      <= n_direction;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Servo payload of the result.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_servo_write <= n_servo_write;
            r_servo_angle <= n_servo_angle;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_motor_run    = r_running;
    assign o_motor_ccw    = r_direction;
    assign o_position_now = w_position_x[OUT_POS_BITS-1:0];
    assign o_servo_write  = r_servo_write;
    assign o_servo_angle  = r_servo_angle;

    // A pass moves the position by at most one step.
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_rst_n) |=>
            (r_position == $past(r_position)) ||
            (r_position == $past(r_position) + POSITION_BITS'(1)) ||
            (r_position == $past(r_position) - POSITION_BITS'(1)))
        else $error("position moved by more than one step in a pass");

    // Without an accepted transaction, position and target hold.
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_in_accept) |=> ($stable(r_position) && $stable(r_target)))
        else $error("position or target changed without a transaction");

    // A stopped motor sits exactly on the target.
    a_stopped_on_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_rst_n) ##1 !r_running |-> (r_position == r_target))
        else $error("motor stopped away from the target");

    // The pending return clears only together with a servo command.
    a_return_with_servo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_return_pending)) |-> r_servo_write)
        else $error("pending return cleared without a servo command");

    // A result with no servo command carries angle zero.
    a_idle_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_servo_write) |-> (r_servo_angle == '0))
        else $error("servo angle nonzero without a servo command");

endmodule
